FILE: rtl/bgls_pkg.sv
`default_nettype none

package bgls_pkg;

  // Configuration register indexes, in the order of the register map.
  localparam int unsigned CfgAddrBits = 3;
  typedef logic [CfgAddrBits-1:0] cfg_addr_t;

  localparam cfg_addr_t REG_LOW_LEVEL     = 3'd0;
  localparam cfg_addr_t REG_MID_LEVEL     = 3'd1;
  localparam cfg_addr_t REG_THREE_QUARTER = 3'd2;
  localparam cfg_addr_t REG_FULL_LEVEL    = 3'd3;
  localparam cfg_addr_t REG_HOT_LEVEL     = 3'd4;
  localparam cfg_addr_t REG_HYST_STEP     = 3'd5;

  // Hysteresis step width, fixed whatever the sample width.
  localparam int unsigned HystBits = 8;
  typedef logic [HystBits-1:0] hyst_t;

  // Level reset values, given for a 10-bit converter.
  localparam int unsigned RefBits         = 10;
  localparam int unsigned LowLevelReset   = 600;
  localparam int unsigned MidLevelReset   = 700;
  localparam int unsigned ThreeQtrReset   = 800;
  localparam int unsigned FullLevelReset  = 900;
  localparam int unsigned HotLevelReset   = 512;
  localparam hyst_t       HystStepReset   = 8'd20;

  // LED patterns (bit 3 is the lowest level, bit 0 the top).
  typedef logic [3:0] led_t;
  localparam led_t LED_NONE    = 4'b0000;
  localparam led_t LED_LOW     = 4'b1000;
  localparam led_t LED_MID     = 4'b0100;
  localparam led_t LED_THREE_Q = 4'b0010;
  localparam led_t LED_TOP     = 4'b0001;
  localparam led_t BAR_LOW     = 4'b1000;
  localparam led_t BAR_MID     = 4'b1100;
  localparam led_t BAR_THREE_Q = 4'b1110;
  localparam led_t BAR_FULL    = 4'b1111;

  // Timer request codes.
  typedef logic [1:0] timer_t;
  localparam timer_t TIMER_NONE    = 2'd0;
  localparam timer_t TIMER_SCAN    = 2'd1;
  localparam timer_t TIMER_STANDBY = 2'd2;

  // Fill animation step, one-hot.
  typedef enum logic [4:0] {
    STEP_LOW     = 5'b00001,
    STEP_MID     = 5'b00010,
    STEP_THREE_Q = 5'b00100,
    STEP_FULL    = 5'b01000,
    STEP_DONE    = 5'b10000
  } fill_step_t;

  // Scales a 10-bit level to another converter width.
  function automatic int unsigned scale_level(int unsigned value, int unsigned bits);
    int unsigned scaled;
    if (bits >= RefBits) begin
      scaled = value << (bits - RefBits);
    end else begin
      scaled = value >> (RefBits - bits);
    end
    return scaled;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bgls_if.sv
`default_nettype none

// Input channel: one tick of samples.
interface bgls_in_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic                   charger_plugged;
  logic [SAMPLE_BITS-1:0] battery_sample;
  logic [SAMPLE_BITS-1:0] temperature_sample;

  modport source (output valid, output charger_plugged, output battery_sample,
                  output temperature_sample, input ready);
  modport sink (input valid, input charger_plugged, input battery_sample,
                input temperature_sample, output ready);
endinterface

// Result channel: LED drive, fan and timer request for one tick.
interface bgls_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] steady_leds;
  logic [3:0] flash_leds;
  logic       fan_on;
  logic [1:0] timer_request;
  logic       battery_full;

  modport source (output valid, output steady_leds, output flash_leds, output fan_on,
                  output timer_request, output battery_full, input ready);
  modport sink (input valid, input steady_leds, input flash_leds, input fan_on,
                input timer_request, input battery_full, output ready);
endinterface

// Configuration write channel.
interface bgls_cfg_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic [2:0]             addr;
  logic [SAMPLE_BITS-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/battery_gauge_led_sequencer.sv
// An input tick passes through the input register and then the result register.
// Throughput: one tick per cycle. While a result waits to be taken, one more tick
// is taken into the empty input register, and the input then stalls until it moves on.
// Reset (rst, synchronous, active high) loads the level defaults, clears the
// animation and mode flags, marks the battery not full and empties both stages.
`default_nettype none

module battery_gauge_led_sequencer #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  bgls_in_if.sink      samples,
  bgls_out_if.source   result,
  bgls_cfg_if.sink     cfg
);
  import bgls_pkg::*;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
  localparam sample_t LOW_RST    = SAMPLE_BITS'(scale_level(LowLevelReset, SAMPLE_BITS));
  localparam sample_t MID_RST    = SAMPLE_BITS'(scale_level(MidLevelReset, SAMPLE_BITS));
  localparam sample_t THREE_RST  = SAMPLE_BITS'(scale_level(ThreeQtrReset, SAMPLE_BITS));
  localparam sample_t FULL_RST   = SAMPLE_BITS'(scale_level(FullLevelReset, SAMPLE_BITS));
  localparam sample_t HOT_RST    = SAMPLE_BITS'(scale_level(HotLevelReset, SAMPLE_BITS));

  // Configuration registers.
  sample_t low_lvl;
  sample_t mid_lvl;
  sample_t three_lvl;
  sample_t full_lvl;
  sample_t hot_lvl;
  hyst_t   hyst_step;

  // Input stage.
  logic    s_valid;
  logic    s_plugged;
  sample_t s_batt;
  sample_t s_temp;

  // Gauge state.
  fill_step_t fill_step, fill_step_next;
  logic       full_shifted, full_shifted_next;
  logic       hot_shifted, hot_shifted_next;
  logic       not_full, not_full_next;
  logic       charging_entered, charging_entered_next;
  logic       standby_entered, standby_entered_next;
  led_t       led_latch, led_latch_next;

  // Result stage.
  logic   r_valid;
  led_t   r_steady;
  led_t   r_flash;
  logic   r_fan;
  timer_t r_timer;
  logic   r_full;

  led_t   flash_next;
  led_t   bar;
  timer_t timer_next;
  logic   fan_next;

  logic               advance;
  sample_t            hyst_ext;
  logic [SAMPLE_BITS:0] hot_sum;
  sample_t            hot_eff;
  sample_t            full_eff;

  assign advance       = s_valid && (!r_valid || result.ready);
  assign samples.ready = !s_valid || advance;
  assign cfg.ready     = 1'b1;

  // Configuration writes; the register width masks the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_lvl   <= LOW_RST;
      mid_lvl   <= MID_RST;
      three_lvl <= THREE_RST;
      full_lvl  <= FULL_RST;
      hot_lvl   <= HOT_RST;
      hyst_step <= HystStepReset;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_LOW_LEVEL:     low_lvl   <= cfg.data;
        REG_MID_LEVEL:     mid_lvl   <= cfg.data;
        REG_THREE_QUARTER: three_lvl <= cfg.data;
        REG_FULL_LEVEL:    full_lvl  <= cfg.data;
        REG_HOT_LEVEL:     hot_lvl   <= cfg.data;
        REG_HYST_STEP:     hyst_step <= cfg.data[HystBits-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s_plugged <= samples.charger_plugged;
      s_batt    <= samples.battery_sample;
      s_temp    <= samples.temperature_sample;
    end
  end

  // Effective thresholds: the fan level rises and the full level drops once crossed.
  assign hyst_ext = SAMPLE_BITS'(hyst_step);
  assign hot_sum  = {1'b0, hot_lvl} + {1'b0, hyst_ext};

  always_comb begin
    if (!hot_shifted) begin
      hot_eff = hot_lvl;
    end else if (hot_sum[SAMPLE_BITS]) begin
      hot_eff = SAMPLE_MAX;
    end else begin
      hot_eff = hot_sum[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    if (!full_shifted) begin
      full_eff = full_lvl;
    end else if (full_lvl > hyst_ext) begin
      full_eff = full_lvl - hyst_ext;
    end else begin
      full_eff = '0;
    end
  end

  // One tick: fan comparator, then the charging animation or the standby bar.
  always_comb begin
    fill_step_next        = fill_step;
    full_shifted_next     = full_shifted;
    not_full_next         = not_full;
    charging_entered_next = charging_entered;
    standby_entered_next  = standby_entered;
    led_latch_next        = led_latch;
    flash_next            = LED_NONE;
    timer_next            = TIMER_NONE;
    bar                   = LED_NONE;

    fan_next         = s_temp < hot_eff;
    hot_shifted_next = fan_next;

    if (s_plugged && not_full) begin
      if (!charging_entered) begin
        charging_entered_next = 1'b1;
        standby_entered_next  = 1'b0;
        timer_next            = TIMER_SCAN;
      end
      unique case (fill_step)
        STEP_LOW: begin
          if (s_batt > low_lvl) begin
            led_latch_next = led_latch | LED_LOW;
            fill_step_next = STEP_MID;
          end
        end
        STEP_MID: begin
          if (s_batt > mid_lvl) begin
            led_latch_next = led_latch | LED_MID;
            fill_step_next = STEP_THREE_Q;
          end else begin
            led_latch_next = LED_NONE;
            fill_step_next = STEP_LOW;
          end
        end
        STEP_THREE_Q: begin
          if (s_batt > three_lvl) begin
            led_latch_next = led_latch | LED_THREE_Q;
            fill_step_next = STEP_FULL;
          end else begin
            led_latch_next = LED_NONE;
            fill_step_next = STEP_LOW;
          end
        end
        STEP_FULL: begin
          if (s_batt > full_eff) begin
            full_shifted_next = 1'b1;
            led_latch_next    = led_latch | LED_TOP;
            fill_step_next    = STEP_DONE;
          end else begin
            full_shifted_next = 1'b0;
            led_latch_next    = LED_NONE;
            fill_step_next    = STEP_LOW;
          end
        end
        STEP_DONE: begin
          led_latch_next = LED_NONE;
          not_full_next  = 1'b0;
          fill_step_next = STEP_LOW;
        end
        default: ;
      endcase
    end else begin
      fill_step_next = STEP_LOW;
      if (!standby_entered) begin
        standby_entered_next  = 1'b1;
        charging_entered_next = 1'b0;
        timer_next            = TIMER_STANDBY;
      end else begin
        // Later passing comparisons override earlier ones.
        if (s_batt > low_lvl) begin
          bar = BAR_LOW;
        end
        if (s_batt > mid_lvl) begin
          bar = BAR_MID;
        end
        if (s_batt > three_lvl) begin
          bar = BAR_THREE_Q;
        end
        not_full_next = 1'b1;
        if (s_batt >= full_eff) begin
          bar           = BAR_FULL;
          not_full_next = 1'b0;
        end
        flash_next     = bar;
        led_latch_next = LED_NONE;
      end
    end
  end

  // State update, once per tick that moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_step        <= STEP_LOW;
      full_shifted     <= 1'b0;
      hot_shifted      <= 1'b0;
      not_full         <= 1'b1;
      charging_entered <= 1'b0;
      standby_entered  <= 1'b0;
      led_latch        <= LED_NONE;
    end else if (advance) begin
      fill_step        <= fill_step_next;
      full_shifted     <= full_shifted_next;
      hot_shifted      <= hot_shifted_next;
      not_full         <= not_full_next;
      charging_entered <= charging_entered_next;
      standby_entered  <= standby_entered_next;
      led_latch        <= led_latch_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= 1'b1;
    end else if (result.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_steady <= led_latch_next;
      r_flash  <= flash_next;
      r_fan    <= fan_next;
      r_timer  <= timer_next;
      r_full   <= !not_full_next;
    end
  end

  assign result.valid         = r_valid;
  assign result.steady_leds   = r_steady;
  assign result.flash_leds    = r_flash;
  assign result.fan_on        = r_fan;
  assign result.timer_request = r_timer;
  assign result.battery_full  = r_full;

`ifndef ASSERT_OFF
  // A flashed bar only comes from a standby tick, which clears the held LEDs.
  a_flash_clears_steady: assert property (@(posedge clk) disable iff (rst)
    r_valid && (r_flash != LED_NONE) |-> (r_steady == LED_NONE))
    else $error("flash bar shown while steady LEDs are lit");

  // The tick that enters standby does not flash.
  a_standby_entry_no_flash: assert property (@(posedge clk) disable iff (rst)
    r_valid && (r_timer == TIMER_STANDBY) |-> (r_flash == LED_NONE))
    else $error("flash bar on the standby entry tick");

  // The held LEDs fill from the bottom, so the top LED implies the full bar.
  a_steady_fills_up: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_steady[0] |-> (r_steady == BAR_FULL))
    else $error("top LED lit without the lower LEDs");

  // The input stage only empties when its tick moves to the result register.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    s_valid && !advance |=> s_valid)
    else $error("input tick dropped");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !r_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

FILE: sim/gauge_checker.sv
`timescale 1ns / 100ps

// Watches the sample, result and configuration channels of the LED sequencer,
// predicts the result of every accepted tick and compares it on arrival.
module gauge_checker #(
  parameter int SampleBits = 10
) (
  input  logic clk,
  input  logic rst,
  bgls_in_if   samples,
  bgls_out_if  result,
  bgls_cfg_if  cfg,
  output int   errors,
  output int   pending
);
  import bgls_pkg::*;

  localparam int unsigned SampleMax = (1 << SampleBits) - 1;

  typedef logic [SampleBits-1:0] sample_t;

  typedef struct packed {
    led_t   steady;
    led_t   flash;
    logic   fan;
    timer_t timer;
    logic   full;
  } gauge_result_t;

  // Predicted gauge state and its own copy of the level registers.
  sample_t       level_q [0:4];
  hyst_t         hyst_q;
  fill_step_t    step_q;
  logic          full_shift_q;
  logic          hot_shift_q;
  logic          not_full_q;
  logic          in_charge_q;
  logic          in_standby_q;
  led_t          led_q;

  gauge_result_t gauge_q [$];
  gauge_result_t want;
  gauge_result_t got;

  // Advances the predicted gauge by one tick and returns the LED, fan and timer outputs.
  function automatic gauge_result_t tick_gauge(logic plugged, sample_t batt, sample_t temp);
    gauge_result_t r;
    int unsigned   full_eff;
    int unsigned   hot_eff;
    led_t          bar;
    r.flash = LED_NONE;
    r.timer = TIMER_NONE;

    // Both thresholds move by the hysteresis step once crossed, with saturation.
    hot_eff = level_q[REG_HOT_LEVEL];
    if (hot_shift_q) begin
      hot_eff = (hot_eff + hyst_q > SampleMax) ? SampleMax : hot_eff + hyst_q;
    end
    full_eff = level_q[REG_FULL_LEVEL];
    if (full_shift_q) begin
      full_eff = (full_eff > hyst_q) ? full_eff - hyst_q : 0;
    end

    // The fan runs while the thermistor reads below the effective hot level.
    r.fan       = (temp < hot_eff);
    hot_shift_q = r.fan;

    if (plugged && not_full_q) begin
      // Charging: one fill step per tick, a failed check restarts the animation.
      if (!in_charge_q) begin
        in_charge_q  = 1'b1;
        in_standby_q = 1'b0;
        r.timer      = TIMER_SCAN;
      end
      case (step_q)
        STEP_LOW: begin
          if (batt > level_q[REG_LOW_LEVEL]) begin
            led_q  = led_q | LED_LOW;
            step_q = STEP_MID;
          end
        end
        STEP_MID: begin
          if (batt > level_q[REG_MID_LEVEL]) begin
            led_q  = led_q | LED_MID;
            step_q = STEP_THREE_Q;
          end else begin
            led_q  = LED_NONE;
            step_q = STEP_LOW;
          end
        end
        STEP_THREE_Q: begin
          if (batt > level_q[REG_THREE_QUARTER]) begin
            led_q  = led_q | LED_THREE_Q;
            step_q = STEP_FULL;
          end else begin
            led_q  = LED_NONE;
            step_q = STEP_LOW;
          end
        end
        STEP_FULL: begin
          // The animation needs a sample strictly above the full level.
          if (batt > full_eff) begin
            full_shift_q = 1'b1;
            led_q        = led_q | LED_TOP;
            step_q       = STEP_DONE;
          end else begin
            full_shift_q = 1'b0;
            led_q        = LED_NONE;
            step_q       = STEP_LOW;
          end
        end
        STEP_DONE: begin
          led_q      = LED_NONE;
          not_full_q = 1'b0;
          step_q     = STEP_LOW;
        end
        default: ;
      endcase
    end else begin
      // Standby: the first tick asks for the standby timer, later ones flash the bar.
      step_q = STEP_LOW;
      if (!in_standby_q) begin
        in_standby_q = 1'b1;
        in_charge_q  = 1'b0;
        r.timer      = TIMER_STANDBY;
      end else begin
        bar = LED_NONE;
        if (batt > level_q[REG_LOW_LEVEL]) bar = BAR_LOW;
        if (batt > level_q[REG_MID_LEVEL]) bar = BAR_MID;
        if (batt > level_q[REG_THREE_QUARTER]) bar = BAR_THREE_Q;
        not_full_q = 1'b1;
        if (batt >= full_eff) begin
          bar        = BAR_FULL;
          not_full_q = 1'b0;
        end
        r.flash = bar;
        led_q   = LED_NONE;
      end
    end

    r.steady = led_q;
    r.full   = !not_full_q;
    return r;
  endfunction

  // Result transfers are checked first; a tick taken at the same edge cannot be among them.
  always @(posedge clk) begin
    if (rst) begin
      level_q[REG_LOW_LEVEL]     = sample_t'(LowLevelReset);
      level_q[REG_MID_LEVEL]     = sample_t'(MidLevelReset);
      level_q[REG_THREE_QUARTER] = sample_t'(ThreeQtrReset);
      level_q[REG_FULL_LEVEL]    = sample_t'(FullLevelReset);
      level_q[REG_HOT_LEVEL]     = sample_t'(HotLevelReset);
      hyst_q       = HystStepReset;
      step_q       = STEP_LOW;
      full_shift_q = 1'b0;
      hot_shift_q  = 1'b0;
      not_full_q   = 1'b1;
      in_charge_q  = 1'b0;
      in_standby_q = 1'b0;
      led_q        = LED_NONE;
      gauge_q.delete();
      errors = 0;
    end else begin
      if (result.valid && result.ready) begin
        got = '{steady: result.steady_leds, flash: result.flash_leds, fan: result.fan_on,
                timer: result.timer_request, full: result.battery_full};
        if (gauge_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, expected none, got",
                   $time, " steady=%b flash=%b fan=%b timer=%0d full=%b",
                   got.steady, got.flash, got.fan, got.timer, got.full);
        end else begin
          want = gauge_q.pop_front();
          if (want !== got) begin
            errors++;
            $display("%0t: result mismatch, expected steady=%b flash=%b fan=%b timer=%0d",
                     $time, want.steady, want.flash, want.fan, want.timer,
                     " full=%b, got steady=%b flash=%b fan=%b timer=%0d full=%b",
                     want.full, got.steady, got.flash, got.fan, got.timer, got.full);
          end
        end
      end

      // Register writes; indexes past the hysteresis step are ignored.
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          REG_LOW_LEVEL, REG_MID_LEVEL, REG_THREE_QUARTER, REG_FULL_LEVEL,
          REG_HOT_LEVEL: level_q[cfg.addr] = cfg.data;
          REG_HYST_STEP: hyst_q = cfg.data[HystBits-1:0];
          default: ;
        endcase
      end

      if (samples.valid && samples.ready) begin
        gauge_q.push_back(tick_gauge(samples.charger_plugged, samples.battery_sample,
                                     samples.temperature_sample));
      end
    end
    pending = gauge_q.size();
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

// Drives ticks and register writes into the LED sequencer and gives the verdict.
module tb_top;
  import bgls_pkg::*;

  localparam int SampleBits  = 10;
  localparam int SampleMax   = (1 << SampleBits) - 1;
  localparam int RandomItems = 450;
  localparam int PhaseItems  = 75;
  localparam int IdleLimit   = 2000;

  typedef logic [SampleBits-1:0] sample_t;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   ticks_sent;
  int   burst_left;

  // Levels as last written, used only to aim samples at the thresholds.
  int unsigned level_shadow [0:5];

  bgls_in_if #(.SAMPLE_BITS(SampleBits)) samples ();
  bgls_out_if result ();
  bgls_cfg_if #(.SAMPLE_BITS(SampleBits)) cfg ();

  battery_gauge_led_sequencer #(.SAMPLE_BITS(SampleBits)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .result  (result),
    .cfg     (cfg)
  );

  gauge_checker #(.SampleBits(SampleBits)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .result  (result),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sample_t clamp(int v);
    if (v < 0) return '0;
    if (v > SampleMax) return sample_t'(SampleMax);
    return sample_t'(v);
  endfunction

  // A sample at, just beside, or one hysteresis step away from a level.
  function automatic sample_t near(int unsigned v);
    int off;
    case ($urandom_range(0, 4))
      0: off = -1;
      1: off = 0;
      2: off = 1;
      3: off = -int'(level_shadow[REG_HYST_STEP]);
      default: off = int'(level_shadow[REG_HYST_STEP]);
    endcase
    return clamp(int'(v) + off);
  endfunction

  function automatic sample_t above(int unsigned thr);
    if (thr >= SampleMax) return sample_t'(SampleMax);
    if ($urandom_range(0, 1) == 0) return sample_t'(thr + 1);
    return sample_t'($urandom_range(thr + 1, SampleMax));
  endfunction

  function automatic sample_t pick_temp();
    case ($urandom_range(0, 3))
      0: return sample_t'($urandom_range(0, SampleMax));
      1: return near(level_shadow[REG_HOT_LEVEL] + level_shadow[REG_HYST_STEP]);
      default: return near(level_shadow[REG_HOT_LEVEL]);
    endcase
  endfunction

  // Offers one tick and returns at the falling edge after its transfer.
  // Ticks go out in bursts; between bursts valid often drops for a random gap.
  task automatic send_tick(input logic plugged, input sample_t batt, input sample_t temp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        samples.valid              <= 1'b0;
        samples.charger_plugged    <= 1'($urandom_range(0, 1));
        samples.battery_sample     <= sample_t'($urandom_range(0, SampleMax));
        samples.temperature_sample <= sample_t'($urandom_range(0, SampleMax));
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    samples.valid              <= 1'b1;
    samples.charger_plugged    <= plugged;
    samples.battery_sample     <= batt;
    samples.temperature_sample <= temp;
    do @(posedge clk); while (!samples.ready);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Stops offering ticks and waits until every predicted result has arrived.
  task automatic settle();
    samples.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_addr_t addr, input int unsigned data);
    cfg.valid <= 1'b1;
    cfg.addr  <= addr;
    cfg.data  <= sample_t'(data);
    do @(posedge clk); while (!cfg.ready);
    if (addr <= REG_HYST_STEP) begin
      level_shadow[addr] = (addr == REG_HYST_STEP) ? (data & 8'hFF) : (data & SampleMax);
    end
    @(negedge clk);
  endtask

  // Loads a full register set while the block is idle, sometimes after a
  // write to an unused index that must change nothing.
  task automatic load_levels(input int unsigned lo, input int unsigned mi,
                             input int unsigned tq, input int unsigned fu,
                             input int unsigned ho, input int unsigned hy);
    settle();
    if ($urandom_range(0, 2) == 0) begin
      write_reg(cfg_addr_t'($urandom_range(REG_HYST_STEP + 1, 7)),
                $urandom_range(0, SampleMax));
    end
    write_reg(REG_LOW_LEVEL, lo);
    write_reg(REG_MID_LEVEL, mi);
    write_reg(REG_THREE_QUARTER, tq);
    write_reg(REG_FULL_LEVEL, fu);
    write_reg(REG_HOT_LEVEL, ho);
    write_reg(REG_HYST_STEP, hy);
    cfg.valid <= 1'b0;
    @(negedge clk);
    burst_left = 0;
  endtask

  // One random stretch: half the time a charge cycle aimed at the levels, else
  // standby readings near the levels, else plain noise.
  task automatic run_sequence();
    int      kind;
    int      len;
    int      k;
    sample_t batt;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      if ($urandom_range(0, 1) == 0) begin
        repeat (2) send_tick(1'b0, near(level_shadow[REG_FULL_LEVEL]), pick_temp());
      end
      len = $urandom_range(5, 7);
      for (k = 0; k < len; k++) begin
        if (k < 4) begin
          batt = ($urandom_range(0, 7) == 0) ? near(level_shadow[k]) : above(level_shadow[k]);
        end else begin
          batt = sample_t'($urandom_range(0, SampleMax));
        end
        send_tick(1'b1, batt, pick_temp());
      end
    end else if (kind < 8) begin
      len = $urandom_range(1, 6);
      for (k = 0; k < len; k++) begin
        send_tick(1'($urandom_range(0, 3) == 0),
                  near(level_shadow[$urandom_range(0, 3)]), pick_temp());
      end
    end else begin
      len = $urandom_range(1, 4);
      for (k = 0; k < len; k++) begin
        send_tick(1'($urandom_range(0, 1)), sample_t'($urandom_range(0, SampleMax)),
                  sample_t'($urandom_range(0, SampleMax)));
      end
    end
  endtask

  // Picks a fresh register set; levels are usually in order, sometimes not.
  task automatic load_random_levels();
    int unsigned lo, mi, tq, fu;
    if ($urandom_range(0, 3) == 0) begin
      lo = $urandom_range(0, SampleMax);
      mi = $urandom_range(0, SampleMax);
      tq = $urandom_range(0, SampleMax);
      fu = $urandom_range(0, SampleMax);
    end else begin
      lo = $urandom_range(0, 700);
      mi = $urandom_range(lo, SampleMax);
      tq = $urandom_range(mi, SampleMax);
      fu = $urandom_range(tq, SampleMax);
    end
    load_levels(lo, mi, tq, fu, $urandom_range(0, SampleMax), $urandom_range(0, SampleMax));
  endtask

  // Result side: a ready pattern that changes between four random modes, with a long
  // hold-off now and then, started while a tick is on offer, so that the
  // block fills and stalls its input.
  initial begin : receiver
    int cycle_n;
    int mode;
    int next_hold;
    int hold_cycles;
    result.ready = 1'b0;
    cycle_n   = 0;
    mode      = 0;
    next_hold = 400;
    forever begin
      @(negedge clk);
      cycle_n++;
      if (cycle_n % 64 == 0) mode = $urandom_range(0, 3);
      if (cycle_n >= next_hold && samples.valid) begin
        hold_cycles = $urandom_range(40, 90);
        result.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        next_hold = cycle_n + $urandom_range(500, 1500);
      end
      case (mode)
        0: result.ready <= 1'b1;
        1: result.ready <= ($urandom_range(0, 3) != 0);
        2: result.ready <= ($urandom_range(0, 3) == 0);
        default: result.ready <= (cycle_n % 5 != 0);
      endcase
    end
  end

  // Ends the run when no channel has had a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (rst || (samples.valid && samples.ready) || (result.valid && result.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("battery_gauge_led_sequencer verification failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int next_cfg;
    int stop_at;
    samples.valid              = 1'b0;
    samples.charger_plugged    = 1'b0;
    samples.battery_sample     = '0;
    samples.temperature_sample = '0;
    cfg.valid  = 1'b0;
    cfg.addr   = REG_LOW_LEVEL;
    cfg.data   = '0;
    ticks_sent = 0;
    burst_left = 0;
    level_shadow[REG_LOW_LEVEL]     = LowLevelReset;
    level_shadow[REG_MID_LEVEL]     = MidLevelReset;
    level_shadow[REG_THREE_QUARTER] = ThreeQtrReset;
    level_shadow[REG_FULL_LEVEL]    = FullLevelReset;
    level_shadow[REG_HOT_LEVEL]     = HotLevelReset;
    level_shadow[REG_HYST_STEP]     = HystStepReset;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Standby bar at the reset levels: a sample equal to the low level shows
    // empty, the full level counts as full at equality, and the fan shifts.
    send_tick(1'b0, 10'd0, 10'd1023);
    send_tick(1'b0, 10'd600, 10'd1023);
    send_tick(1'b0, 10'd601, 10'd511);
    send_tick(1'b0, 10'd701, 10'd531);
    send_tick(1'b0, 10'd801, 10'd532);
    send_tick(1'b0, 10'd899, 10'd0);
    send_tick(1'b0, 10'd900, 10'd1023);
    send_tick(1'b0, 10'd1023, 10'd512);
    send_tick(1'b0, 10'd0, 10'd0);

    // Charging: a fill step at exactly the full level fails, then a complete fill.
    send_tick(1'b1, 10'd601, 10'd700);
    send_tick(1'b1, 10'd701, 10'd300);
    send_tick(1'b1, 10'd801, 10'd511);
    send_tick(1'b1, 10'd900, 10'd513);
    send_tick(1'b1, 10'd601, 10'd1023);
    send_tick(1'b1, 10'd701, 10'd100);
    send_tick(1'b1, 10'd801, 10'd900);
    send_tick(1'b1, 10'd901, 10'd512);
    send_tick(1'b1, 10'd0, 10'd20);

    // Plugged but full goes to standby; the full level is now shifted down.
    send_tick(1'b1, 10'd500, 10'd532);
    send_tick(1'b1, 10'd880, 10'd531);
    send_tick(1'b0, 10'd879, 10'd1000);

    // A fill that stalls at the low level and then fails at the mid level.
    send_tick(1'b1, 10'd600, 10'd0);
    send_tick(1'b1, 10'd601, 10'd1023);
    send_tick(1'b1, 10'd650, 10'd511);
    send_tick(1'b1, 10'd1023, 10'd600);

    // Random part, with the register set changed between phases.
    phase    = 0;
    next_cfg = ticks_sent + 40;
    stop_at  = ticks_sent + RandomItems;
    while (ticks_sent < stop_at) begin
      if (ticks_sent >= next_cfg) begin
        case (phase)
          0: load_levels(0, 0, 0, 0, 0, 0);
          1: load_levels(SampleMax, SampleMax, SampleMax, SampleMax, SampleMax, SampleMax);
          2: load_levels(50, 60, 80, 100, 950, 200);
          3: load_levels(800, 300, 500, 200, 512, 40);
          default: load_random_levels();
        endcase
        phase++;
        next_cfg = ticks_sent + PhaseItems;
      end
      run_sequence();
    end

    samples.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("battery_gauge_led_sequencer verification clean");
    end else begin
      $display("battery_gauge_led_sequencer verification failed");
    end
    $finish;
  end

endmodule

FILE: battery_gauge_led_sequencer.f
rtl/bgls_pkg.sv
rtl/bgls_if.sv
rtl/battery_gauge_led_sequencer.sv
sim/gauge_checker.sv
sim/tb_top.sv
